FILE: hdl/mabf_pkg.sv
package mabf_pkg;

	localparam int COLOR_W    = 8;
	localparam int WORD_W     = 25;
	localparam int KNOWN_POS  = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam int GRID_W     = 7;
	localparam int FRAC_W     = 17;
	localparam int WGT_W      = 33;
	localparam int SUM_W      = 34;
	localparam int ACC_W      = 40;
	localparam int CNT_W      = 5;

	localparam logic [FRAC_W-1:0] Q_ONE = 17'h10000;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_FACTOR  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

	localparam logic [GRID_W-1:0]     GRID_RESET   = 7'd2;
	localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 9'd256;
	localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 9'd256;

	localparam logic [CNT_W-1:0] MOD_LAST  = 5'd7;
	localparam logic [CNT_W-1:0] READ_LAST = 5'd4;
	localparam logic [CNT_W-1:0] FRAC_LAST = 5'd16;
	localparam logic [CNT_W-1:0] WGT_LAST  = 5'd4;
	localparam logic [CNT_W-1:0] DIV_LAST  = 5'd7;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MOD,
		ST_CORNER,
		ST_READ,
		ST_DECIDE,
		ST_FRAC,
		ST_WEIGHT,
		ST_DIVIDE
	} state_t;

endpackage

FILE: hdl/mask_aware_bilinear_fill.sv
// A write command is stored at its accepting edge and gives no result; busy stays low.
// A query of a known pixel raises done after the check state reads it, a query that
// falls back to a corner color after the corner reads, and a blended query after the divide.
// One query is worked at a time and busy drops with done, so the next word can be accepted
// while done is high; the memory port and the bit-serial dividers set the length of a query.
// Reset clears the control state and sets the registers to their reset values; the
// frame memory is not cleared, and the receiver cannot stall a result.
module mask_aware_bilinear_fill #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            command,
	input  logic [7:0]                      row,
	input  logic [7:0]                      col,
	input  logic [7:0]                      in_blue,
	input  logic [7:0]                      in_green,
	input  logic [7:0]                      in_red,
	input  logic                            known,
	input  logic                            cfg_we,
	input  logic [mabf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mabf_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                            done,
	output logic [7:0]                      out_blue,
	output logic [7:0]                      out_green,
	output logic [7:0]                      out_red
);
	import mabf_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int MW    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int DW    = ($clog2(MW) + 1 > 9) ? $clog2(MW) + 1 : 9;

	function automatic logic [AW-1:0] pix_addr(input logic [DW-1:0] r, input logic [DW-1:0] c);
		pix_addr = AW'(r * MAX_WIDTH + c);
	endfunction

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;
	logic [AW-1:0]     raddr;
	logic              wr_en;

	logic [GRID_W-1:0]     grid_q;
	logic [CFG_DATA_W-1:0] width_q;
	logic [CFG_DATA_W-1:0] height_q;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;

	logic [GRID_W-1:0] f_eff;
	logic [DW-1:0]     cols, rows, cols_m1, rows_m1;
	logic [7:0]        xin_c, yin_c;

	logic [7:0]        xc_q, yc_q, x0_q, y0_q;
	logic [GRID_W-1:0] xr_q, yr_q;
	logic [DW-1:0]     x1_q, y1_q;
	logic [7:0]        dxn_q, dyn_q;
	logic [GRID_W-1:0] dxd_q, dyd_q;
	logic [FRAC_W-1:0] dx_q, dy_q;
	logic [WORD_W-1:0] crn_q [4];
	logic [WGT_W-1:0]  wf_s1;
	logic              kn_s1;
	logic [23:0]       col_s1;
	logic [SUM_W-1:0]  wsum_q;
	logic [ACC_W-1:0]  acc_q [3];
	logic [7:0]        quo_q [3];
	logic [7:0]        ob_q, og_q, or_q;

	logic [7:0]        xmod_t, ymod_t;
	logic [DW-1:0]     x1_raw, y1_raw, x1_c, y1_c;
	logic [7:0]        fx_t, fy_t;
	logic              fx_ge, fy_ge;
	logic [FRAC_W-1:0] dxe, dye, wa, wb;
	logic              any_known, single, fallback;
	logic [ACC_W:0]    dv;
	logic              qbit [3];
	logic [ACC_W-1:0]  acc_nx [3];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q   <= GRID_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_GRID_FACTOR) grid_q <= cfg_data[GRID_W-1:0];
			if (cfg_index == REG_FRAME_WIDTH) width_q <= cfg_data;
			if (cfg_index == REG_FRAME_HEIGHT) height_q <= cfg_data;
		end
	end

	always_comb begin
		f_eff   = (grid_q == '0) ? GRID_W'(1) : grid_q;
		cols    = (width_q == '0) ? DW'(1) :
			(DW'(width_q) > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(width_q);
		rows    = (height_q == '0) ? DW'(1) :
			(DW'(height_q) > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : DW'(height_q);
		cols_m1 = cols - DW'(1);
		rows_m1 = rows - DW'(1);
		xin_c   = (DW'(col) > cols_m1) ? cols_m1[7:0] : col;
		yin_c   = (DW'(row) > rows_m1) ? rows_m1[7:0] : row;
	end

	// Frame memory.
	assign wr_en = start && !busy && (command == CMD_WRITE) &&
		(int'(row) < MAX_HEIGHT) && (int'(col) < MAX_WIDTH);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[pix_addr(DW'(row), DW'(col))] <= {known, in_red, in_green, in_blue};
		end
		rdata_q <= mem[raddr];
	end

	// Datapath helpers.
	always_comb begin
		xmod_t = {xr_q, xc_q[~cnt_q[2:0]]};
		ymod_t = {yr_q, yc_q[~cnt_q[2:0]]};
		x1_raw = DW'(xc_q - 8'(xr_q)) + DW'(f_eff);
		y1_raw = DW'(yc_q - 8'(yr_q)) + DW'(f_eff);
		x1_c   = (x1_raw > cols_m1) ? cols_m1 : x1_raw;
		y1_c   = (y1_raw > rows_m1) ? rows_m1 : y1_raw;
		fx_t   = (cnt_q == '0) ? dxn_q : {dxn_q[6:0], 1'b0};
		fy_t   = (cnt_q == '0) ? dyn_q : {dyn_q[6:0], 1'b0};
		fx_ge  = fx_t >= {1'b0, dxd_q};
		fy_ge  = fy_t >= {1'b0, dyd_q};
		dxe    = (dxd_q == '0) ? '0 : dx_q;
		dye    = (dyd_q == '0) ? '0 : dy_q;
		wa     = cnt_q[0] ? dxe : Q_ONE - dxe;
		wb     = cnt_q[1] ? dye : Q_ONE - dye;
		any_known = crn_q[0][KNOWN_POS] | crn_q[1][KNOWN_POS] |
			crn_q[2][KNOWN_POS] | crn_q[3][KNOWN_POS];
		single    = (DW'(x0_q) == x1_q) && (DW'(y0_q) == y1_q);
		fallback  = !any_known || (single && crn_q[0][KNOWN_POS]);
		dv        = (ACC_W+1)'(wsum_q) << (~cnt_q[2:0]);
		for (int k = 0; k < 3; k++) begin
			qbit[k]   = {1'b0, acc_q[k]} >= dv;
			acc_nx[k] = qbit[k] ? acc_q[k] - dv[ACC_W-1:0] : acc_q[k];
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (start && command == CMD_QUERY) state_d = ST_CHECK;
			ST_CHECK:  state_d = rdata_q[KNOWN_POS] ? ST_IDLE : ST_MOD;
			ST_MOD:    if (cnt_q == MOD_LAST) state_d = ST_CORNER;
			ST_CORNER: state_d = ST_READ;
			ST_READ:   if (cnt_q == READ_LAST) state_d = ST_DECIDE;
			ST_DECIDE: state_d = fallback ? ST_IDLE : ST_FRAC;
			ST_FRAC:   if (cnt_q == FRAC_LAST) state_d = ST_WEIGHT;
			ST_WEIGHT: if (cnt_q == WGT_LAST) state_d = ST_DIVIDE;
			ST_DIVIDE: if (cnt_q == DIV_LAST) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		busy  = (state_q != ST_IDLE);
		raddr = pix_addr(DW'(yin_c), DW'(xin_c));
		if (state_q == ST_READ) begin
			unique case (cnt_q[1:0])
				2'd0: raddr = pix_addr(DW'(y0_q), DW'(x0_q));
				2'd1: raddr = pix_addr(DW'(y0_q), x1_q);
				2'd2: raddr = pix_addr(y1_q, DW'(x0_q));
				2'd3: raddr = pix_addr(y1_q, x1_q);
				default: raddr = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? '0 : cnt_q + CNT_W'(1);
			done_q  <= ((state_q == ST_CHECK) && rdata_q[KNOWN_POS]) ||
				((state_q == ST_DECIDE) && fallback) ||
				((state_q == ST_DIVIDE) && (cnt_q == DIV_LAST));
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				xc_q <= xin_c;
				yc_q <= yin_c;
				xr_q <= '0;
				yr_q <= '0;
			end
			ST_CHECK: begin
				ob_q <= rdata_q[7:0];
				og_q <= rdata_q[15:8];
				or_q <= rdata_q[23:16];
			end
			ST_MOD: begin
				xr_q <= (xmod_t >= {1'b0, f_eff}) ? 7'(xmod_t - {1'b0, f_eff}) : xmod_t[6:0];
				yr_q <= (ymod_t >= {1'b0, f_eff}) ? 7'(ymod_t - {1'b0, f_eff}) : ymod_t[6:0];
			end
			ST_CORNER: begin
				x0_q  <= xc_q - 8'(xr_q);
				y0_q  <= yc_q - 8'(yr_q);
				x1_q  <= x1_c;
				y1_q  <= y1_c;
				dxn_q <= {1'b0, xr_q};
				dyn_q <= {1'b0, yr_q};
				dxd_q <= 7'(x1_c - DW'(xc_q - 8'(xr_q)));
				dyd_q <= 7'(y1_c - DW'(yc_q - 8'(yr_q)));
			end
			ST_READ: begin
				if (cnt_q != '0) begin
					crn_q[0] <= crn_q[1];
					crn_q[1] <= crn_q[2];
					crn_q[2] <= crn_q[3];
					crn_q[3] <= rdata_q;
				end
			end
			ST_DECIDE: begin
				ob_q   <= crn_q[0][7:0];
				og_q   <= crn_q[0][15:8];
				or_q   <= crn_q[0][23:16];
				wsum_q <= '0;
				for (int k = 0; k < 3; k++) acc_q[k] <= '0;
			end
			ST_FRAC: begin
				dxn_q <= fx_ge ? fx_t - {1'b0, dxd_q} : fx_t;
				dyn_q <= fy_ge ? fy_t - {1'b0, dyd_q} : fy_t;
				dx_q  <= {dx_q[FRAC_W-2:0], fx_ge};
				dy_q  <= {dy_q[FRAC_W-2:0], fy_ge};
			end
			ST_WEIGHT: begin
				if (cnt_q != WGT_LAST) begin
					wf_s1    <= WGT_W'(wa) * WGT_W'(wb);
					kn_s1    <= crn_q[0][KNOWN_POS];
					col_s1   <= crn_q[0][23:0];
					crn_q[0] <= crn_q[1];
					crn_q[1] <= crn_q[2];
					crn_q[2] <= crn_q[3];
					crn_q[3] <= crn_q[0];
				end
				if (cnt_q != '0 && kn_s1) begin
					wsum_q <= wsum_q + SUM_W'(wf_s1);
					for (int k = 0; k < 3; k++) begin
						acc_q[k] <= acc_q[k] + ACC_W'(wf_s1) * ACC_W'(col_s1[8*k +: 8]);
					end
				end
			end
			ST_DIVIDE: begin
				for (int k = 0; k < 3; k++) begin
					acc_q[k] <= acc_nx[k];
					quo_q[k] <= {quo_q[k][6:0], qbit[k]};
				end
				if (cnt_q == DIV_LAST) begin
					ob_q <= (wsum_q == '0) ? '0 : {quo_q[0][6:0], qbit[0]};
					og_q <= (wsum_q == '0) ? '0 : {quo_q[1][6:0], qbit[1]};
					or_q <= (wsum_q == '0) ? '0 : {quo_q[2][6:0], qbit[2]};
				end
			end
			default: ;
		endcase
	end

	assign done      = done_q;
	assign out_blue  = ob_q;
	assign out_green = og_q;
	assign out_red   = or_q;

endmodule

FILE: hdl/mabf_checker.sv
module mabf_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic command,
	input logic done
);
	import mabf_pkg::*;

	// A result word only ends a query that kept the block busy.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result word without a busy query");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command == CMD_WRITE) |=> !done)
		else $error("write command produced a result word");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command == CMD_QUERY) |=> busy)
		else $error("query accepted without going busy");

	a_single_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("two result words in a row");

endmodule

bind mask_aware_bilinear_fill mabf_checker u_mabf_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.command (command),
	.done    (done)
);
